// ===== design/ogec_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the occupancy grid edge cost block: map geometry,
// field widths, operation and register codes and register reset values.
// Depends on nothing; used by occupancy_grid_edge_cost.
package ogec_pkg;

   localparam int MAX_ROWS      = 256;
   localparam int MAX_COLS      = 256;
   localparam int MAX_INFLATION = 15;

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ADDR_W  = ROW_W + COL_W;
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int COORD_W = 9;
   localparam int SCOORD_W = COORD_W + 1;
   localparam int PIX_W   = 8;
   localparam int COST_W  = 16;
   localparam int INFL_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [PIX_W-1:0] CELL_OUTSIDE = 8'd255;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INFLATION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAGONAL  = 3'd5;

   localparam logic [COORD_W-1:0] RST_GRID_ROWS = 9'd256;
   localparam logic [COORD_W-1:0] RST_GRID_COLS = 9'd256;
   localparam logic [INFL_W-1:0]  RST_INFLATION = 4'd1;
   localparam logic [PIX_W-1:0]   RST_THRESHOLD = 8'd178;
   localparam logic [COST_W-1:0]  RST_STRAIGHT  = 16'd256;
   localparam logic [COST_W-1:0]  RST_DIAGONAL  = 16'd362;

   localparam logic [0:0] KIND_CHANGE = 1'b0;
   localparam logic [0:0] KIND_COST   = 1'b1;

endpackage

// ===== design/occupancy_grid_edge_cost.sv =====
`timescale 1ns / 1ps
// Occupancy grid edge cost block: the map memory, raster writer and the
// sequencer that walks inflation windows through one compare unit.
// Depends on ogec_pkg.
//
// Usage. An item is taken when start is high and busy is low. Operation load
// writes the next raster pixel, update does the same and reports the cell
// when its value changed, query returns the cost of the edge between two
// corner nodes. Results appear for one cycle with rsp_strobe high; the
// receiver cannot stall them and must take every transfer as it comes.
// Registers are written over the csr_ channel, which is always ready, while
// the block is idle: a rule for the user that the block does not enforce.
// Timing. Load and update pass through the pixel state; a change report is
// on the result ports in the cycle after that. A query passes through a decode
// state, then for each cell it inspects (one for a diagonal edge, two for a
// straight one) a setup state, a walk over the map entries of its clipped
// window (at most 961; none for a cell outside the map) and a next state, then
// a result state (decode alone for nodes that are not adjacent); the answer is
// on the result ports as busy falls. The walk reads one map entry per cycle.
// Reset clears the raster position and the sequencer, loads register reset
// values. The map contents are undefined until written and are not cleared.
module occupancy_grid_edge_cost (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic [ogec_pkg::PIX_W-1:0]          req_pixel_value,
   input  logic [ogec_pkg::COORD_W-1:0]        req_node_row,
   input  logic [ogec_pkg::COORD_W-1:0]        req_node_col,
   input  logic [ogec_pkg::COORD_W-1:0]        req_next_row,
   input  logic [ogec_pkg::COORD_W-1:0]        req_next_col,
   output logic                                rsp_strobe,
   output logic                                rsp_kind,
   output logic [ogec_pkg::ROW_W-1:0]          rsp_cell_row,
   output logic [ogec_pkg::COL_W-1:0]          rsp_cell_col,
   output logic [ogec_pkg::COST_W-1:0]         rsp_path_cost,
   output logic                                rsp_blocked,
   output logic                                rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ogec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ogec_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PIX    = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_SETUP  = 3'd3;
   localparam logic [2:0] ST_WALK   = 3'd4;
   localparam logic [2:0] ST_NEXT   = 3'd5;
   localparam logic [2:0] ST_RESULT = 3'd6;

   localparam int ROW_W    = ogec_pkg::ROW_W;
   localparam int COL_W    = ogec_pkg::COL_W;
   localparam int COORD_W  = ogec_pkg::COORD_W;
   localparam int SCOORD_W = ogec_pkg::SCOORD_W;
   localparam int PIX_W    = ogec_pkg::PIX_W;
   localparam int COST_W   = ogec_pkg::COST_W;
   localparam int INFL_W   = ogec_pkg::INFL_W;

   logic [PIX_W-1:0] map_mem [ogec_pkg::DEPTH];

   logic [2:0]   state_ff, state_in;
   logic [ROW_W-1:0] raster_row_ff, raster_row_in;
   logic [COL_W-1:0] raster_col_ff, raster_col_in;

   logic [COORD_W-1:0] grid_rows_ff, grid_cols_ff;
   logic [INFL_W-1:0]  inflation_ff;
   logic [PIX_W-1:0]   threshold_ff;
   logic [COST_W-1:0]  straight_ff, diagonal_ff;

   logic [1:0]         op_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;

   logic                      diag_ff, diag_in;
   logic                      two_cells_ff, two_cells_in;
   logic                      cell_idx_ff, cell_idx_in;
   logic signed [SCOORD_W-1:0] cell0_r_ff, cell0_r_in, cell0_c_ff, cell0_c_in;
   logic signed [SCOORD_W-1:0] cell1_r_ff, cell1_r_in, cell1_c_ff, cell1_c_in;
   logic [ROW_W-1:0]          r_lo_ff, r_lo_in, r_hi_ff, r_hi_in, r_ff, r_in;
   logic [COL_W-1:0]          c_lo_ff, c_lo_in, c_hi_ff, c_hi_in, c_ff, c_in;
   logic [PIX_W-1:0]          acc_ff, acc_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [PIX_W-1:0]          rd_data_ff;
   logic [ogec_pkg::ADDR_W-1:0] rd_addr, raster_addr;
   logic                      mem_we;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [ROW_W-1:0]          rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]          rsp_col_ff, rsp_col_in;
   logic [COST_W-1:0]         rsp_cost_ff, rsp_cost_in;
   logic                      rsp_blocked_ff, rsp_blocked_in;
   logic                      rsp_status_ff, rsp_status_in;

   logic [COORD_W-1:0] rows_used, cols_used;
   logic [INFL_W-1:0]  half_w;
   logic               accept;

   logic signed [SCOORD_W-1:0] dx, dy, x1_s, y1_s;
   logic dx_one, dx_neg, dy_one, dy_neg;
   logic signed [SCOORD_W-1:0] cur_r, cur_c;
   logic               outside;
   logic signed [SCOORD_W-1:0] r_low_s, c_low_s;
   logic [COORD_W-1:0] r_high, c_high;
   logic [COORD_W-1:0] col_step, row_step;
   logic [PIX_W-1:0]   rd_val;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rows_used = (grid_rows_ff == '0) ? COORD_W'(1) :
                      (grid_rows_ff > COORD_W'(ogec_pkg::MAX_ROWS)) ?
                      COORD_W'(ogec_pkg::MAX_ROWS) : grid_rows_ff;
   assign cols_used = (grid_cols_ff == '0) ? COORD_W'(1) :
                      (grid_cols_ff > COORD_W'(ogec_pkg::MAX_COLS)) ?
                      COORD_W'(ogec_pkg::MAX_COLS) : grid_cols_ff;
   assign half_w    = (inflation_ff == '0) ? INFL_W'(1) :
                      (inflation_ff > INFL_W'(ogec_pkg::MAX_INFLATION)) ?
                      INFL_W'(ogec_pkg::MAX_INFLATION) : inflation_ff;

   assign raster_addr = {raster_row_ff, raster_col_ff};
   assign rd_addr     = (state_ff == ST_WALK) ? {r_ff, c_ff} : raster_addr;
   assign mem_we      = (state_ff == ST_PIX);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[raster_addr] <= pix_ff;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign x1_s   = $signed({1'b0, x1_ff});
   assign y1_s   = $signed({1'b0, y1_ff});
   assign dx     = $signed({1'b0, x2_ff}) - x1_s;
   assign dy     = $signed({1'b0, y2_ff}) - y1_s;
   assign dx_one = (dx == SCOORD_W'(1));
   assign dx_neg = (dx == -SCOORD_W'(1));
   assign dy_one = (dy == SCOORD_W'(1));
   assign dy_neg = (dy == -SCOORD_W'(1));

   assign cur_r   = cell_idx_ff ? cell1_r_ff : cell0_r_ff;
   assign cur_c   = cell_idx_ff ? cell1_c_ff : cell0_c_ff;
   assign outside = (cur_r < 0) || (cur_c < 0) ||
                    (cur_r >= $signed({1'b0, rows_used})) ||
                    (cur_c >= $signed({1'b0, cols_used}));
   assign r_low_s = cur_r - $signed({{(SCOORD_W-INFL_W){1'b0}}, half_w});
   assign c_low_s = cur_c - $signed({{(SCOORD_W-INFL_W){1'b0}}, half_w});
   assign r_high  = {1'b0, cur_r[ROW_W-1:0]} + {{(COORD_W-INFL_W){1'b0}}, half_w};
   assign c_high  = {1'b0, cur_c[COL_W-1:0]} + {{(COORD_W-INFL_W){1'b0}}, half_w};

   assign col_step = {1'b0, raster_col_ff} + COORD_W'(1);
   assign row_step = {1'b0, raster_row_ff} + COORD_W'(1);

   assign rd_val = rd_pend_ff ? rd_data_ff : '0;

   always_comb begin
      state_in       = state_ff;
      raster_row_in  = raster_row_ff;
      raster_col_in  = raster_col_ff;
      diag_in        = diag_ff;
      two_cells_in   = two_cells_ff;
      cell_idx_in    = cell_idx_ff;
      cell0_r_in     = cell0_r_ff;
      cell0_c_in     = cell0_c_ff;
      cell1_r_in     = cell1_r_ff;
      cell1_c_in     = cell1_c_ff;
      r_lo_in        = r_lo_ff;
      r_hi_in        = r_hi_ff;
      c_lo_in        = c_lo_ff;
      c_hi_in        = c_hi_ff;
      r_in           = r_ff;
      c_in           = c_ff;
      rd_pend_in     = 1'b0;
      acc_in         = (rd_val > acc_ff) ? rd_val : acc_ff;
      rsp_strobe_in  = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == ogec_pkg::OP_LOAD ||
                   req_operation == ogec_pkg::OP_UPDATE) begin
                  state_in = ST_PIX;
               end else if (req_operation == ogec_pkg::OP_QUERY) begin
                  state_in = ST_DECODE;
               end
            end
         end
         ST_PIX: begin
            if (op_ff == ogec_pkg::OP_UPDATE && rd_data_ff != pix_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_kind_in    = ogec_pkg::KIND_CHANGE;
               rsp_row_in     = raster_row_ff;
               rsp_col_in     = raster_col_ff;
               rsp_cost_in    = '0;
               rsp_blocked_in = 1'b0;
               rsp_status_in  = 1'b0;
            end
            if (col_step >= cols_used) begin
               raster_col_in = '0;
               if (row_step >= rows_used) begin
                  raster_row_in = '0;
               end else begin
                  raster_row_in = row_step[ROW_W-1:0];
               end
            end else begin
               raster_col_in = col_step[COL_W-1:0];
            end
            state_in = ST_IDLE;
         end
         ST_DECODE: begin
            acc_in      = '0;
            cell_idx_in = 1'b0;
            if ((dx_one || dx_neg) && (dy_one || dy_neg)) begin
               diag_in      = 1'b1;
               two_cells_in = 1'b0;
               cell0_r_in   = dx_one ? x1_s : x1_s - SCOORD_W'(1);
               cell0_c_in   = dy_one ? y1_s : y1_s - SCOORD_W'(1);
               state_in     = ST_SETUP;
            end else if (dy == '0 && (dx_one || dx_neg)) begin
               diag_in      = 1'b0;
               two_cells_in = 1'b1;
               cell0_r_in   = dx_one ? x1_s : x1_s - SCOORD_W'(1);
               cell1_r_in   = dx_one ? x1_s : x1_s - SCOORD_W'(1);
               cell0_c_in   = y1_s;
               cell1_c_in   = y1_s - SCOORD_W'(1);
               state_in     = ST_SETUP;
            end else if (dx == '0 && (dy_one || dy_neg)) begin
               diag_in      = 1'b0;
               two_cells_in = 1'b1;
               cell0_r_in   = x1_s - SCOORD_W'(1);
               cell1_r_in   = x1_s;
               cell0_c_in   = dy_one ? y1_s : y1_s - SCOORD_W'(1);
               cell1_c_in   = dy_one ? y1_s : y1_s - SCOORD_W'(1);
               state_in     = ST_SETUP;
            end else begin
               rsp_strobe_in  = 1'b1;
               rsp_kind_in    = ogec_pkg::KIND_COST;
               rsp_row_in     = '0;
               rsp_col_in     = '0;
               rsp_cost_in    = '0;
               rsp_blocked_in = 1'b0;
               rsp_status_in  = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SETUP: begin
            if (outside) begin
               acc_in   = ogec_pkg::CELL_OUTSIDE;
               state_in = ST_NEXT;
            end else begin
               r_lo_in  = (r_low_s < 0) ? '0 : r_low_s[ROW_W-1:0];
               c_lo_in  = (c_low_s < 0) ? '0 : c_low_s[COL_W-1:0];
               r_hi_in  = (r_high >= rows_used) ? ROW_W'(rows_used - COORD_W'(1)) :
                          r_high[ROW_W-1:0];
               c_hi_in  = (c_high >= cols_used) ? COL_W'(cols_used - COORD_W'(1)) :
                          c_high[COL_W-1:0];
               r_in     = r_lo_in;
               c_in     = c_lo_in;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_pend_in = 1'b1;
            if (c_ff == c_hi_ff) begin
               c_in = c_lo_ff;
               if (r_ff == r_hi_ff) begin
                  state_in = ST_NEXT;
               end else begin
                  r_in = r_ff + ROW_W'(1);
               end
            end else begin
               c_in = c_ff + COL_W'(1);
            end
         end
         ST_NEXT: begin
            if (two_cells_ff && !cell_idx_ff) begin
               cell_idx_in = 1'b1;
               state_in    = ST_SETUP;
            end else begin
               state_in    = ST_RESULT;
            end
         end
         ST_RESULT: begin
            rsp_strobe_in  = 1'b1;
            rsp_kind_in    = ogec_pkg::KIND_COST;
            rsp_row_in     = '0;
            rsp_col_in     = '0;
            rsp_status_in  = 1'b0;
            rsp_blocked_in = (acc_ff > threshold_ff);
            if (acc_ff > threshold_ff) begin
               rsp_cost_in = '0;
            end else begin
               rsp_cost_in = diag_ff ? diagonal_ff : straight_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         raster_row_ff <= '0;
         raster_col_ff <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         grid_rows_ff  <= ogec_pkg::RST_GRID_ROWS;
         grid_cols_ff  <= ogec_pkg::RST_GRID_COLS;
         inflation_ff  <= ogec_pkg::RST_INFLATION;
         threshold_ff  <= ogec_pkg::RST_THRESHOLD;
         straight_ff   <= ogec_pkg::RST_STRAIGHT;
         diagonal_ff   <= ogec_pkg::RST_DIAGONAL;
      end else begin
         state_ff      <= state_in;
         raster_row_ff <= raster_row_in;
         raster_col_ff <= raster_col_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ogec_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_data[COORD_W-1:0];
               ogec_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_data[COORD_W-1:0];
               ogec_pkg::CSR_INFLATION: inflation_ff <= csr_data[INFL_W-1:0];
               ogec_pkg::CSR_THRESHOLD: threshold_ff <= csr_data[PIX_W-1:0];
               ogec_pkg::CSR_STRAIGHT:  straight_ff  <= csr_data[COST_W-1:0];
               ogec_pkg::CSR_DIAGONAL:  diagonal_ff  <= csr_data[COST_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         pix_ff <= req_pixel_value;
         x1_ff  <= req_node_row;
         y1_ff  <= req_node_col;
         x2_ff  <= req_next_row;
         y2_ff  <= req_next_col;
      end
      diag_ff        <= diag_in;
      two_cells_ff   <= two_cells_in;
      cell_idx_ff    <= cell_idx_in;
      cell0_r_ff     <= cell0_r_in;
      cell0_c_ff     <= cell0_c_in;
      cell1_r_ff     <= cell1_r_in;
      cell1_c_ff     <= cell1_c_in;
      r_lo_ff        <= r_lo_in;
      r_hi_ff        <= r_hi_in;
      c_lo_ff        <= c_lo_in;
      c_hi_ff        <= c_hi_in;
      r_ff           <= r_in;
      c_ff           <= c_in;
      acc_ff         <= acc_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_cell_row  = rsp_row_ff;
   assign rsp_cell_col  = rsp_col_ff;
   assign rsp_path_cost = rsp_cost_ff;
   assign rsp_blocked   = rsp_blocked_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== tb/sv/occupancy_grid_edge_cost_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for occupancy_grid_edge_cost: a scoreboard class predicts change
// reports and edge costs from its own copy of the map and registers; plain tasks drive items.
// Depends on ogec_pkg and the occupancy_grid_edge_cost RTL.
module occupancy_grid_edge_cost_test;

   localparam int ROW_W      = ogec_pkg::ROW_W;
   localparam int COL_W      = ogec_pkg::COL_W;
   localparam int COORD_W    = ogec_pkg::COORD_W;
   localparam int PIX_W      = ogec_pkg::PIX_W;
   localparam int COST_W     = ogec_pkg::COST_W;
   localparam int INFL_W     = ogec_pkg::INFL_W;
   localparam int CSR_IDX_W  = ogec_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = ogec_pkg::CSR_DATA_W;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                kind;
      logic [ROW_W-1:0]    cell_row;
      logic [COL_W-1:0]    cell_col;
      logic [COST_W-1:0]   path_cost;
      logic                blocked;
      logic                status;
   } grid_answer_type;

   class grid_scoreboard;
      logic [PIX_W-1:0]   cells [ogec_pkg::DEPTH];
      bit                 filled [ogec_pkg::DEPTH];
      int                 raster_row;
      int                 raster_col;
      logic [COORD_W-1:0] rows_reg;
      logic [COORD_W-1:0] cols_reg;
      logic [INFL_W-1:0]  infl_reg;
      logic [PIX_W-1:0]   thr_reg;
      logic [COST_W-1:0]  straight_reg;
      logic [COST_W-1:0]  diag_reg;
      grid_answer_type    pending_answers [$];
      int                 errors;

      function new();
         raster_row   = 0;
         raster_col   = 0;
         rows_reg     = ogec_pkg::RST_GRID_ROWS;
         cols_reg     = ogec_pkg::RST_GRID_COLS;
         infl_reg     = ogec_pkg::RST_INFLATION;
         thr_reg      = ogec_pkg::RST_THRESHOLD;
         straight_reg = ogec_pkg::RST_STRAIGHT;
         diag_reg     = ogec_pkg::RST_DIAGONAL;
         errors       = 0;
      endfunction

      function int rows_used();
         if (rows_reg == 0) return 1;
         if (rows_reg > ogec_pkg::MAX_ROWS) return ogec_pkg::MAX_ROWS;
         return int'(rows_reg);
      endfunction

      function int cols_used();
         if (cols_reg == 0) return 1;
         if (cols_reg > ogec_pkg::MAX_COLS) return ogec_pkg::MAX_COLS;
         return int'(cols_reg);
      endfunction

      function int half_width();
         if (infl_reg == 0) return 1;
         if (infl_reg > ogec_pkg::MAX_INFLATION) return ogec_pkg::MAX_INFLATION;
         return int'(infl_reg);
      endfunction

      function int cell_addr(int row, int col);
         return (row % ogec_pkg::MAX_ROWS) * ogec_pkg::MAX_COLS + (col % ogec_pkg::MAX_COLS);
      endfunction

      function bit raster_filled();
         return filled[cell_addr(raster_row, raster_col)];
      endfunction

      function logic [PIX_W-1:0] raster_pixel();
         return cells[cell_addr(raster_row, raster_col)];
      endfunction

      function logic [PIX_W-1:0] inflated(int row, int col);
         int               nr;
         int               nc;
         int               h;
         int               r0;
         int               r1;
         int               c0;
         int               c1;
         logic [PIX_W-1:0] best;
         nr = rows_used();
         nc = cols_used();
         h  = half_width();
         if (row < 0 || col < 0 || row >= nr || col >= nc) return ogec_pkg::CELL_OUTSIDE;
         best = '0;
         r0 = (row - h < 0) ? 0 : row - h;
         r1 = (row + h + 1 > nr) ? nr : row + h + 1;
         c0 = (col - h < 0) ? 0 : col - h;
         c1 = (col + h + 1 > nc) ? nc : col + h + 1;
         for (int r = r0; r < r1; r++) begin
            for (int c = c0; c < c1; c++) begin
               if (cells[cell_addr(r, c)] > best) best = cells[cell_addr(r, c)];
            end
         end
         return best;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            ogec_pkg::CSR_GRID_ROWS: rows_reg     = data[COORD_W-1:0];
            ogec_pkg::CSR_GRID_COLS: cols_reg     = data[COORD_W-1:0];
            ogec_pkg::CSR_INFLATION: infl_reg     = data[INFL_W-1:0];
            ogec_pkg::CSR_THRESHOLD: thr_reg      = data[PIX_W-1:0];
            ogec_pkg::CSR_STRAIGHT:  straight_reg = data[COST_W-1:0];
            ogec_pkg::CSR_DIAGONAL:  diag_reg     = data[COST_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] op, logic [PIX_W-1:0] pix,
                                 logic [COORD_W-1:0] nr, logic [COORD_W-1:0] nc,
                                 logic [COORD_W-1:0] xr, logic [COORD_W-1:0] xc);
         grid_answer_type  ans;
         int               a;
         int               x1;
         int               y1;
         int               dr;
         int               dc;
         int               side;
         bit               changed;
         logic [PIX_W-1:0] v;
         logic [PIX_W-1:0] v2;
         ans = '0;
         if (op == ogec_pkg::OP_LOAD || op == ogec_pkg::OP_UPDATE) begin
            a = cell_addr(raster_row, raster_col);
            changed = 1'b0;
            if (op == ogec_pkg::OP_UPDATE) changed = (cells[a] != pix);
            ans.kind     = ogec_pkg::KIND_CHANGE;
            ans.cell_row = ROW_W'(raster_row);
            ans.cell_col = COL_W'(raster_col);
            cells[a]  = pix;
            filled[a] = 1'b1;
            raster_col++;
            if (raster_col >= cols_used()) begin
               raster_col = 0;
               raster_row++;
               if (raster_row >= rows_used()) raster_row = 0;
            end
            if (changed) pending_answers = {pending_answers, ans};
            return;
         end
         if (op != ogec_pkg::OP_QUERY) return;
         x1 = int'(nr);
         y1 = int'(nc);
         dr = int'(xr) - x1;
         dc = int'(xc) - y1;
         ans.kind = ogec_pkg::KIND_COST;
         if ((dr == 1 || dr == -1) && (dc == 1 || dc == -1)) begin
            v = inflated(dr == 1 ? x1 : x1 - 1, dc == 1 ? y1 : y1 - 1);
            if (v > thr_reg) ans.blocked = 1'b1;
            else ans.path_cost = diag_reg;
         end else if ((dc == 0 && (dr == 1 || dr == -1)) ||
                      (dr == 0 && (dc == 1 || dc == -1))) begin
            if (dc == 0) begin
               side = (dr == 1) ? x1 : x1 - 1;
               v  = inflated(side, y1);
               v2 = inflated(side, y1 - 1);
            end else begin
               side = (dc == 1) ? y1 : y1 - 1;
               v  = inflated(x1 - 1, side);
               v2 = inflated(x1, side);
            end
            if (v2 > v) v = v2;
            if (v > thr_reg) ans.blocked = 1'b1;
            else ans.path_cost = straight_reg;
         end else begin
            ans.status = 1'b1;
         end
         pending_answers = {pending_answers, ans};
      endfunction

      function void check_answer(grid_answer_type got);
         grid_answer_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result kind=%0d row=%0d col=%0d cost=%0d %s%0d %s%0d",
                     $time, got.kind, got.cell_row, got.cell_col, got.path_cost,
                     "blocked=", got.blocked, "status=", got.status);
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d row=%0d col=%0d cost=%0d %s%0d %s%0d",
                     $time, want.kind, want.cell_row, want.cell_col, want.path_cost,
                     "blocked=", want.blocked, "status=", want.status);
            $display("%0t:          actual kind=%0d row=%0d col=%0d cost=%0d %s%0d %s%0d",
                     $time, got.kind, got.cell_row, got.cell_col, got.path_cost,
                     "blocked=", got.blocked, "status=", got.status);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_operation = ogec_pkg::OP_LOAD;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic [COORD_W-1:0]    req_node_row = '0;
   logic [COORD_W-1:0]    req_node_col = '0;
   logic [COORD_W-1:0]    req_next_row = '0;
   logic [COORD_W-1:0]    req_next_col = '0;
   logic                  rsp_strobe;
   logic                  rsp_kind;
   logic [ROW_W-1:0]      rsp_cell_row;
   logic [COL_W-1:0]      rsp_cell_col;
   logic [COST_W-1:0]     rsp_path_cost;
   logic                  rsp_blocked;
   logic                  rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   grid_scoreboard        board = new();
   grid_answer_type       seen;
   bit                    steady = 1'b0;
   int                    items_sent = 0;

   occupancy_grid_edge_cost u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_pixel_value (req_pixel_value),
      .req_node_row    (req_node_row),
      .req_node_col    (req_node_col),
      .req_next_row    (req_next_row),
      .req_next_col    (req_next_col),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_col    (rsp_cell_col),
      .rsp_path_cost   (rsp_path_cost),
      .rsp_blocked     (rsp_blocked),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen.kind      = rsp_kind;
         seen.cell_row  = rsp_cell_row;
         seen.cell_col  = rsp_cell_col;
         seen.path_cost = rsp_path_cost;
         seen.blocked   = rsp_blocked;
         seen.status    = rsp_status;
         board.check_answer(seen);
      end
   end

   function automatic int gap_cycles();
      int p;
      if (steady) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      int p;
      p = $urandom_range(0, 9);
      if (p < 6) return PIX_W'($urandom_range(0, 120));
      if (p < 9) return PIX_W'($urandom_range(0, 255));
      return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
   endfunction

   function automatic logic [COORD_W-1:0] junk_coord();
      return COORD_W'($urandom_range(0, 256));
   endfunction

   function automatic int clamp_node(int v);
      return (v < 0) ? 0 : ((v > 256) ? 256 : v);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] dress(logic [CSR_DATA_W-1:0] v, int w);
      if ($urandom_range(0, 3) != 0) return v;
      return v | (CSR_DATA_W'($urandom_range(0, 65535)) << w);
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [PIX_W-1:0] pix,
                            input logic [COORD_W-1:0] nr, input logic [COORD_W-1:0] nc,
                            input logic [COORD_W-1:0] xr, input logic [COORD_W-1:0] xc);
      int idle;
      start           <= 1'b1;
      req_operation   <= op;
      req_pixel_value <= pix;
      req_node_row    <= nr;
      req_node_col    <= nc;
      req_next_row    <= xr;
      req_next_col    <= xc;
      do @(posedge clock); while (busy);
      board.note_request(op, pix, nr, nc, xr, xc);
      items_sent++;
      idle = gap_cycles();
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic ask(input int nr, input int nc, input int xr, input int xc);
      send_item(ogec_pkg::OP_QUERY, pick_pixel(), COORD_W'(nr), COORD_W'(nc),
                COORD_W'(xr), COORD_W'(xc));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_grid(input logic [CSR_DATA_W-1:0] rows, input logic [CSR_DATA_W-1:0] cols,
                               input logic [CSR_DATA_W-1:0] infl, input logic [CSR_DATA_W-1:0] thr,
                               input logic [CSR_DATA_W-1:0] sc, input logic [CSR_DATA_W-1:0] dc);
      write_csr(ogec_pkg::CSR_GRID_ROWS, rows);
      write_csr(ogec_pkg::CSR_GRID_COLS, cols);
      write_csr(ogec_pkg::CSR_INFLATION, infl);
      write_csr(ogec_pkg::CSR_THRESHOLD, thr);
      write_csr(ogec_pkg::CSR_STRAIGHT, sc);
      write_csr(ogec_pkg::CSR_DIAGONAL, dc);
   endtask

   task automatic load_pixel(input logic [PIX_W-1:0] pix);
      send_item(ogec_pkg::OP_LOAD, pix, junk_coord(), junk_coord(), junk_coord(), junk_coord());
   endtask

   task automatic update_pixel(input logic [PIX_W-1:0] pix);
      send_item(ogec_pkg::OP_UPDATE, pix, junk_coord(), junk_coord(), junk_coord(), junk_coord());
   endtask

   // Writes at a raster position left outside the map by a resize come first, then one full pass.
   task automatic fill_map();
      int n;
      while (board.raster_row >= board.rows_used() || board.raster_col >= board.cols_used()) begin
         load_pixel(pick_pixel());
      end
      n = board.rows_used() * board.cols_used();
      repeat (n) begin
         if (board.raster_filled() && $urandom_range(0, 3) == 0) update_pixel(pick_pixel());
         else load_pixel(pick_pixel());
      end
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while ((busy || board.pending_answers.size() != 0) && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (board.pending_answers.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, board.pending_answers.size());
         board.errors += board.pending_answers.size();
         board.pending_answers.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic random_item();
      int k;
      int q;
      int r;
      int c;
      int dr;
      int dc;
      k = $urandom_range(0, 99);
      if (k < 55) begin
         q = $urandom_range(0, 9);
         r = $urandom_range(0, board.rows_used());
         c = $urandom_range(0, board.cols_used());
         if ($urandom_range(0, 15) == 0) r = 256;
         if ($urandom_range(0, 15) == 0) c = 256;
         if (q < 8) begin
            do begin
               dr = int'($urandom_range(0, 2)) - 1;
               dc = int'($urandom_range(0, 2)) - 1;
            end while (dr == 0 && dc == 0);
         end else if (q == 8) begin
            dr = int'($urandom_range(0, 4)) - 2;
            dc = int'($urandom_range(0, 4)) - 2;
         end else begin
            dr = int'($urandom_range(0, 256)) - r;
            dc = int'($urandom_range(0, 256)) - c;
         end
         ask(r, c, clamp_node(r + dr), clamp_node(c + dc));
      end else if (k < 75) begin
         if (!board.raster_filled()) load_pixel(pick_pixel());
         else if ($urandom_range(0, 3) == 0) update_pixel(board.raster_pixel());
         else update_pixel(pick_pixel());
      end else if (k < 95) begin
         load_pixel(pick_pixel());
      end else begin
         send_item(OP_UNUSED, pick_pixel(), junk_coord(), junk_coord(), junk_coord(), junk_coord());
      end
   endtask

   task automatic random_run(input int count);
      repeat (count) random_item();
      settle();
   endtask

   initial begin
      int rows;
      int cols;
      int infl;
      bit big;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_grid(16'd4, 16'd5, 16'd1, 16'd178, 16'd256, 16'd362);
      fill_map();
      load_pixel(8'd0);
      load_pixel(8'd255);
      update_pixel(board.raster_pixel());
      update_pixel(~board.raster_pixel());
      send_item(OP_UNUSED, 8'hFF, 9'd256, 9'd256, 9'd256, 9'd256);
      ask(1, 1, 2, 2);
      ask(2, 2, 1, 1);
      ask(1, 2, 2, 1);
      ask(2, 1, 1, 2);
      ask(1, 1, 2, 1);
      ask(2, 1, 1, 1);
      ask(1, 1, 1, 2);
      ask(1, 2, 1, 1);
      ask(0, 0, 1, 1);
      ask(0, 0, 0, 1);
      ask(0, 0, 1, 0);
      ask(4, 5, 3, 4);
      ask(4, 5, 4, 4);
      ask(2, 2, 2, 2);
      ask(0, 0, 2, 0);
      ask(256, 256, 255, 255);
      ask(0, 0, 256, 256);
      ask(256, 256, 256, 255);
      settle();

      program_grid(16'd40, 16'd1, 16'd15, 16'd0, 16'd0, 16'd65535);
      fill_map();
      random_run(40);

      steady = 1'b1;
      program_grid(16'd1, 16'd40, 16'd0, 16'd255, 16'd65535, 16'd0);
      fill_map();
      random_run(40);
      steady = 1'b0;

      program_grid(16'hFE00, 16'd300, 16'd15, 16'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      fill_map();
      random_run(40);

      while (items_sent < 750) begin
         big  = ($urandom_range(0, 4) == 0);
         rows = big ? $urandom_range(1, 24) : $urandom_range(1, 10);
         cols = big ? $urandom_range(1, 24) : $urandom_range(1, 10);
         infl = big ? $urandom_range(1, 15) : $urandom_range(1, 4);
         steady = ($urandom_range(0, 3) == 0);
         program_grid(dress(16'(rows), COORD_W), dress(16'(cols), COORD_W),
                      dress(16'(infl), INFL_W), dress(16'($urandom_range(0, 255)), PIX_W),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         fill_map();
         random_run($urandom_range(40, 80));
      end

      settle();
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/ogec_pkg.sv
design/occupancy_grid_edge_cost.sv
tb/sv/occupancy_grid_edge_cost_test.sv
